// File: hw/rtl/lcdw_pkg.sv
package lcdw_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      OP_COMMAND   = 2'd0,
      OP_CHARACTER = 2'd1,
      OP_CURSOR    = 2'd2,
      OP_NUMBER    = 2'd3
   } op_type;

   // One request transaction
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
      logic [1:0]         row;
      logic [3:0]         column;
   } req_type;

   // One display bus write
   typedef struct packed {
      logic       register_select;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_MULTIPLY,
      ST_SPLIT,
      ST_CURSOR,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // Which write the datapath places on the result port
   typedef enum logic [1:0] {
      EMIT_SINGLE,
      EMIT_CURSOR,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_type;

   // Controller to datapath
   typedef struct packed {
      logic     load;
      logic     multiply;
      logic     split;
      logic     pop;
      emit_type emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic number_neg;
      logic quotient_zero;
      logic last_digit;
   } status_type;

   localparam logic [7:0] SET_CURSOR = 8'h80;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // DDRAM start address of each display row
   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] offset;
      unique case (row)
         2'd0:    offset = 8'h00;
         2'd1:    offset = 8'h40;
         2'd2:    offset = 8'h10;
         default: offset = 8'h50;
      endcase
      return offset;
   endfunction

endpackage

// File: hw/rtl/lcdw_ctrl.sv
module lcdw_ctrl
   import lcdw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] op,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the writes of one transaction
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.emit     = EMIT_SINGLE;
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (op_type'(op) == OP_NUMBER) ? ST_MULTIPLY : ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = status.quotient_zero ? ST_CURSOR : ST_MULTIPLY;
         end
         ST_CURSOR: begin
            cmd.emit   = EMIT_CURSOR;
            rsp_strobe = 1'b1;
            state_in   = status.number_neg ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            cmd.emit   = EMIT_SIGN;
            rsp_strobe = 1'b1;
            state_in   = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.emit   = EMIT_DIGIT;
            cmd.pop    = 1'b1;
            rsp_strobe = 1'b1;
            if (status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/lcdw_datapath.sv
module lcdw_datapath
   import lcdw_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic       clock,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_item
);

   localparam int W          = NUMBER_WIDTH;
   // Decimal digits of the largest magnitude, 2**(W-1)
   localparam int MAX_DIGITS = ((W - 1) * 30103) / 100000 + 1;
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   // floor(2**(W+3) / 10): quotient estimate is exact or one short
   localparam logic [63:0] RECIP_FULL = (64'd1 << (W + 3)) / 64'd10;
   localparam logic [W-1:0] RECIP     = RECIP_FULL[W-1:0];

   logic [W-1:0]       number;
   logic [W-1:0]       mag_ff;
   logic [2*W-1:0]     product_ff;
   logic               neg_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [3:0]         stack_ff [MAX_DIGITS];
   logic               single_rs_ff;
   logic [7:0]         single_byte_ff;

   logic [W-4:0] quot_est;
   logic [W:0]   ten_quot;
   logic [W:0]   diff;
   logic         fix;
   logic [W-1:0] quot;
   logic [3:0]   digit;
   logic [7:0]   single_byte;
   logic         single_rs;

   assign number = req_item.value[W-1:0];

   // Work out the one-write requests at load time
   always_comb begin
      single_rs   = 1'b0;
      single_byte = req_item.value[7:0];
      unique case (op_type'(req_item.op))
         OP_COMMAND: begin
            single_rs   = 1'b0;
         end
         OP_CHARACTER: begin
            single_rs   = 1'b1;
         end
         OP_CURSOR: begin
            single_byte = SET_CURSOR | ({4'b0, req_item.column} + row_offset(req_item.row));
         end
         OP_NUMBER: begin
            single_rs   = 1'b1;
         end
         default: begin
            single_rs   = 1'b0;
         end
      endcase
   end

   // Quotient estimate from the registered product, then correct by one
   assign quot_est = product_ff[2*W-1:W+3];
   assign ten_quot = {1'b0, quot_est, 3'b000} + {3'b000, quot_est, 1'b0};
   assign diff     = {1'b0, mag_ff} - ten_quot;
   assign fix      = (diff >= (W + 1)'(10));
   assign quot     = {3'b000, quot_est} + W'(fix);
   assign digit    = fix ? 4'(diff - (W + 1)'(10)) : diff[3:0];

   // Magnitude, product, digit stack
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff         <= number[W-1];
         mag_ff         <= number[W-1] ? (~number + W'(1)) : number;
         count_ff       <= '0;
         single_rs_ff   <= single_rs;
         single_byte_ff <= single_byte;
      end
      if (cmd.multiply) begin
         product_ff <= (2 * W)'(mag_ff) * (2 * W)'(RECIP);
      end
      // Push the new digit on top; the most significant ends up on top
      if (cmd.split) begin
         mag_ff      <= quot;
         count_ff    <= count_ff + COUNT_W'(1);
         stack_ff[0] <= digit;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end
      // Drop the digit just written
      if (cmd.pop) begin
         count_ff <= count_ff - COUNT_W'(1);
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   assign status.number_neg    = neg_ff;
   assign status.quotient_zero = (quot == '0);
   assign status.last_digit    = (count_ff == COUNT_W'(1));

   // Select the write on the result port
   always_comb begin
      rsp_item = '0;
      unique case (cmd.emit)
         EMIT_SINGLE: begin
            rsp_item.register_select = single_rs_ff;
            rsp_item.bus_byte        = single_byte_ff;
            rsp_item.last            = 1'b1;
         end
         EMIT_CURSOR: begin
            rsp_item.register_select = 1'b0;
            rsp_item.bus_byte        = SET_CURSOR | row_offset(2'd1);
            rsp_item.last            = 1'b0;
         end
         EMIT_SIGN: begin
            rsp_item.register_select = 1'b1;
            rsp_item.bus_byte        = CHAR_MINUS;
            rsp_item.last            = 1'b0;
         end
         EMIT_DIGIT: begin
            rsp_item.register_select = 1'b1;
            rsp_item.bus_byte        = CHAR_ZERO | {4'b0, stack_ff[0]};
            rsp_item.last            = status.last_digit;
         end
         default: begin
            rsp_item = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/char_lcd_write_engine.sv
// Channel   Ports                    Handshake
// request   start, busy, req_item    taken at a clock edge with start high, busy low
// result    rsp_strobe, rsp_item     one write per strobe, strobe high, no back-pressure
//
// Raw command, character and cursor move: one write. Print integer: for each
// digit a divide-by-ten step (multiply by reciprocal, then correct), then
// the cursor move to the start of row 1, a minus sign if negative, and the
// digits from the most significant. Busy until the final write. Synchronous
// reset idles the controller; the receiver cannot stall, so writes run back to
// back.
module char_lcd_write_engine
   import lcdw_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   lcdw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_item.op),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   lcdw_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // An accepted transaction keeps the engine busy
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // Writes only come from a transaction in progress
   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("write strobed while idle");

   // The final write frees the engine
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !busy)
      else $error("engine still busy after final write");

   // A write that is not final is followed within the same transaction
   a_more_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=> busy && rsp_strobe)
      else $error("transaction ended without final write");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lcdw_pkg::*;

   localparam int NUMBER_WIDTH  = 32;
   localparam int RANDOM_ITEMS  = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int cycle_count = 0;

   // Predicts the display writes of each request and checks them in order
   class lcd_write_scoreboard;
      rsp_type expected_writes[$];
      int      requests_by_kind[4];
      int      writes_checked;
      int      mismatches;
      int      failures;

      function new();
         writes_checked = 0;
         mismatches     = 0;
         failures       = 0;
         foreach (requests_by_kind[k]) requests_by_kind[k] = 0;
      endfunction

      // DDRAM address of column 0 on each row
      function logic [7:0] row_base(logic [1:0] row);
         case (row)
            2'd0:    return 8'h00;
            2'd1:    return 8'h40;
            2'd2:    return 8'h10;
            default: return 8'h50;
         endcase
      endfunction

      function void queue_write(logic rs, logic [7:0] data, logic last);
         rsp_type w;
         w.register_select = rs;
         w.bus_byte        = data;
         w.last            = last;
         expected_writes.push_back(w);
      endfunction

      // Expand one accepted transaction into its bus writes
      function void note_request(req_type r);
         logic [NUMBER_WIDTH-1:0] number;
         logic [NUMBER_WIDTH-1:0] magnitude;
         logic [7:0]              digit_text[$];
         logic                    negative;
         requests_by_kind[r.op]++;
         case (op_type'(r.op))
            OP_COMMAND:   queue_write(1'b0, r.value[7:0], 1'b1);
            OP_CHARACTER: queue_write(1'b1, r.value[7:0], 1'b1);
            OP_CURSOR:
               queue_write(1'b0, SET_CURSOR | (8'(r.column) + row_base(r.row)), 1'b1);
            default: begin
               number    = r.value[NUMBER_WIDTH-1:0];
               negative  = number[NUMBER_WIDTH-1];
               // take the magnitude unsigned so the most negative value survives
               magnitude = negative ? (~number + 1'b1) : number;
               do begin
                  digit_text.push_front(CHAR_ZERO + 8'(magnitude % 10));
                  magnitude = magnitude / 10;
               end while (magnitude != 0);
               queue_write(1'b0, SET_CURSOR | row_base(2'd1), 1'b0);
               if (negative) queue_write(1'b1, CHAR_MINUS, 1'b0);
               foreach (digit_text[i])
                  queue_write(1'b1, digit_text[i], i == digit_text.size() - 1);
            end
         endcase
      endfunction

      function void report_mismatch(string what, rsp_type want, rsp_type got);
         failures++;
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                     $realtime, what, want.register_select, want.bus_byte, want.last,
                     got.register_select, got.bus_byte, got.last);
      endfunction

      // Compare one observed write against the oldest prediction
      function void check_write(rsp_type got);
         rsp_type want;
         if (expected_writes.size() == 0) begin
            report_mismatch("write with nothing pending", '0, got);
            return;
         end
         want = expected_writes.pop_front();
         writes_checked++;
         if (got.register_select !== want.register_select || got.bus_byte !== want.bus_byte ||
             got.last !== want.last)
            report_mismatch("write mismatch", want, got);
      endfunction
   endclass

   lcd_write_scoreboard sb = new();

   char_lcd_write_engine #(.NUMBER_WIDTH(NUMBER_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_item);
         if (rsp_strobe) sb.check_write(rsp_item);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d writes outstanding",
                  cycle_count, sb.expected_writes.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_req(op_type op, logic [31:0] value,
                                        logic [1:0] row, logic [3:0] column);
      req_type r;
      r.op     = op;
      r.value  = value;
      r.row    = row;
      r.column = column;
      return r;
   endfunction

   // Integers biased towards digit-count boundaries and extremes
   function automatic logic [31:0] pick_number();
      logic [31:0] n;
      int          k;
      case ($urandom_range(0, 4))
         0: n = $urandom;
         1: n = $urandom_range(0, 999);
         2: begin
            n = 1;
            k = $urandom_range(0, 9);
            repeat (k) n = n * 10;
            n = n - $urandom_range(0, 1);
         end
         3: n = $urandom >> $urandom_range(0, 31);
         default: n = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
      if ($urandom_range(0, 1)) n = ~n + 1;
      return n;
   endfunction

   function automatic req_type random_request();
      op_type op;
      op = op_type'($urandom_range(0, 3));
      return make_req(op, (op == OP_NUMBER) ? pick_number() : 32'($urandom),
                      2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
   endfunction

   // Present one transaction and hold it until the block takes it
   task automatic send_request(req_type r);
      req_item = r;
      start    = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop start for a random burst now and then
   task automatic maybe_idle();
      if ($urandom_range(0, 2) == 0) begin
         start    = 1'b0;
         req_item = random_request();
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Hold off until every predicted write has been seen, then let the block settle
   task automatic drain_writes();
      start = 1'b0;
      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      req_type directed[$];
      int      i;

      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Byte extremes with junk in the ignored upper bits
      directed.push_back(make_req(OP_COMMAND,   32'h0000_0000, 2'd3, 4'hF));
      directed.push_back(make_req(OP_COMMAND,   32'hFFFF_FFFF, 2'd0, 4'h0));
      directed.push_back(make_req(OP_COMMAND,   32'h1234_5601, 2'd2, 4'h5));
      directed.push_back(make_req(OP_CHARACTER, 32'h0000_0041, 2'd1, 4'hA));
      directed.push_back(make_req(OP_CHARACTER, 32'hFFFF_FF00, 2'd3, 4'h3));
      directed.push_back(make_req(OP_CHARACTER, 32'h5A5A_5AFF, 2'd0, 4'hC));
      // Every row offset, column corners
      directed.push_back(make_req(OP_CURSOR,    32'hFFFF_FFFF, 2'd0, 4'h0));
      directed.push_back(make_req(OP_CURSOR,    32'h0000_0000, 2'd1, 4'hF));
      directed.push_back(make_req(OP_CURSOR,    32'h8000_0000, 2'd2, 4'h9));
      directed.push_back(make_req(OP_CURSOR,    32'h7FFF_FFFF, 2'd3, 4'hF));
      directed.push_back(make_req(OP_CURSOR,    32'h0000_0001, 2'd3, 4'h0));
      // Zero, sign handling, digit-count boundaries, most negative value
      directed.push_back(make_req(OP_NUMBER,    32'd0,         2'd2, 4'h7));
      directed.push_back(make_req(OP_NUMBER,    32'd7,         2'd0, 4'h1));
      directed.push_back(make_req(OP_NUMBER,    -32'sd1,       2'd3, 4'hE));
      directed.push_back(make_req(OP_NUMBER,    32'd10,        2'd1, 4'h2));
      directed.push_back(make_req(OP_NUMBER,    -32'sd10,      2'd0, 4'h8));
      directed.push_back(make_req(OP_NUMBER,    32'h7FFF_FFFF, 2'd2, 4'h4));
      directed.push_back(make_req(OP_NUMBER,    32'h8000_0000, 2'd1, 4'hB));
      directed.push_back(make_req(OP_NUMBER,    -32'sd1000000000, 2'd3, 4'h6));
      directed.push_back(make_req(OP_NUMBER,    32'd1000000000,  2'd0, 4'hD));
      directed.push_back(make_req(OP_NUMBER,    32'd999999999,   2'd2, 4'h0));
      directed.push_back(make_req(OP_NUMBER,    -32'sd9,         2'd1, 4'hF));

      foreach (directed[k]) begin
         send_request(directed[k]);
         maybe_idle();
      end

      // Let the pipeline run dry before the random part
      drain_writes();

      // Random transactions; gaps in the early part, back to back at the end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         send_request(random_request());
         if (i == RANDOM_ITEMS / 2)
            drain_writes();
         else if (i < RANDOM_ITEMS * 4 / 5)
            maybe_idle();
      end

      drain_writes();
      sb.failures += sb.expected_writes.size();

      $display("Covered %0d requests: %0d commands, %0d characters, %0d cursor moves, %0d integers",
               sb.requests_by_kind[OP_COMMAND] + sb.requests_by_kind[OP_CHARACTER] +
               sb.requests_by_kind[OP_CURSOR] + sb.requests_by_kind[OP_NUMBER],
               sb.requests_by_kind[OP_COMMAND], sb.requests_by_kind[OP_CHARACTER],
               sb.requests_by_kind[OP_CURSOR], sb.requests_by_kind[OP_NUMBER]);
      $display("Checked %0d display writes, %0d mismatches", sb.writes_checked, sb.mismatches);
      if (sb.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_ctrl.sv
hw/rtl/lcdw_datapath.sv
hw/rtl/char_lcd_write_engine.sv
dv/testbench.sv
